FILE: rtl/nearest_neighbor_downscaler_defines.svh
// Assertion macros for the nearest-neighbor downscaler.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NND_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NND_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is asserted.
`define NND_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/nnd_pkg.sv
// Shared types and constants of the nearest-neighbor downscaler.
// No dependencies; imported by the interfaces and every module.
package nnd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Register field widths as seen on the configuration port.
  localparam int CFG_DIM_W = 13;
  localparam int PCT_W     = 7;
  localparam int PCT_FULL  = 100;
  localparam int PIX_W     = 8;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  // Clamped sizes and counters.
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Division by 100 as multiply by ceil(2^26/100) and shift; exact for
  // products below 2^26/36, which covers sizes up to 16384 at 100 percent.
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((2 ** RECIP_SHIFT + 99) / 100);

  // Signed error terms j*W - c*Wo and i*H - r*Ho.
  localparam int DIM_MAX_W = (W_W > H_W) ? W_W : H_W;
  localparam int ACC_W     = 2 * DIM_MAX_W + 1;
  typedef logic signed [ACC_W-1:0] acc_t;

  // Cycles that input is held off after reset or a register write.
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_SCALE_PERCENT
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pix_t;

  // Frame geometry and control handed from the register block to the core.
  typedef struct packed {
    logic [W_W-1:0] w;
    logic [H_W-1:0] h;
    logic [W_W-1:0] wo;
    logic [H_W-1:0] ho;
    logic           active;
    logic           settled;
    logic           restart;
  } cfg_t;

endpackage

FILE: rtl/nnd_stream_if.sv
// Valid/ready stream interfaces for input pixels and kept pixels.
// Depends on nnd_pkg for the component width.
interface nnd_pix_if import nnd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] red_in;

  modport source (output valid, output blue_in, output green_in, output red_in,
                  input ready);
  modport sink   (input valid, input blue_in, input green_in, input red_in,
                  output ready);
endinterface

interface nnd_res_if import nnd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] red_out;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input blue_out, input green_out, input red_out,
                  input row_end, input frame_end, output ready);
endinterface

FILE: rtl/nnd_cfg.sv
// Configuration registers and output-size computation of the downscaler.
// Depends on nnd_pkg; feeds a cfg_t bundle to nnd_core.
module nnd_cfg import nnd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [CFG_DIM_W-1:0] fw_r, fh_r;
  logic [PCT_W-1:0]     pct_r;
  logic [1:0]           settle_r;

  logic [W_W-1:0]       wc_r, wc_nxt;
  logic [H_W-1:0]       hc_r, hc_nxt;
  logic [W_W+PCT_W-1:0] wp_r;
  logic [H_W+PCT_W-1:0] hp_r;
  logic                 pok_r;
  logic [W_W-1:0]       wo_r;
  logic [H_W-1:0]       ho_r;
  logic                 active_r;

  logic [W_W+PCT_W+RECIP_W-1:0] wq;
  logic [H_W+PCT_W+RECIP_W-1:0] hq;
  logic [W_W-1:0]               wo_nxt;
  logic [H_W-1:0]               ho_nxt;

  logic     wr;
  logic     wr_valid;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_SCALE_PERCENT: wr_valid = wr;
      default:                                              wr_valid = 1'b0;
    endcase
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:   prdata = DATA_W'(fw_r);
      REG_FRAME_HEIGHT:  prdata = DATA_W'(fh_r);
      REG_SCALE_PERCENT: prdata = DATA_W'(pct_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= CFG_DIM_W'(640);
      fh_r     <= CFG_DIM_W'(480);
      pct_r    <= PCT_W'(PCT_FULL);
      settle_r <= SETTLE_CYCLES;
    end else begin
      if (wr_valid) begin
        unique case (idx)
          REG_FRAME_WIDTH:   fw_r  <= pwdata[CFG_DIM_W-1:0];
          REG_FRAME_HEIGHT:  fh_r  <= pwdata[CFG_DIM_W-1:0];
          REG_SCALE_PERCENT: pct_r <= pwdata[PCT_W-1:0];
          default:           ;
        endcase
      end
      if (wr) begin
        settle_r <= SETTLE_CYCLES;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // Clamp the sizes into 1..MAX; zero counts as one.
  always_comb begin
    if (fw_r == '0) begin
      wc_nxt = W_W'(1);
    end else if (int'(fw_r) > MAX_WIDTH) begin
      wc_nxt = W_W'(MAX_WIDTH);
    end else begin
      wc_nxt = W_W'(fw_r);
    end
    if (fh_r == '0) begin
      hc_nxt = H_W'(1);
    end else if (int'(fh_r) > MAX_HEIGHT) begin
      hc_nxt = H_W'(MAX_HEIGHT);
    end else begin
      hc_nxt = H_W'(fh_r);
    end
  end

  assign wq     = (W_W+PCT_W+RECIP_W)'(wp_r) * (W_W+PCT_W+RECIP_W)'(RECIP_100);
  assign hq     = (H_W+PCT_W+RECIP_W)'(hp_r) * (H_W+PCT_W+RECIP_W)'(RECIP_100);
  assign wo_nxt = pok_r ? W_W'(wq >> RECIP_SHIFT) : '0;
  assign ho_nxt = pok_r ? H_W'(hq >> RECIP_SHIFT) : '0;

  // Two-stage size pipeline: size times percent, then divide by 100.
  always_ff @(posedge clk) begin
    wc_r     <= wc_nxt;
    hc_r     <= hc_nxt;
    wp_r     <= (W_W+PCT_W)'(wc_nxt) * (W_W+PCT_W)'(pct_r);
    hp_r     <= (H_W+PCT_W)'(hc_nxt) * (H_W+PCT_W)'(pct_r);
    pok_r    <= (pct_r != '0) && (int'(pct_r) <= PCT_FULL);
    wo_r     <= wo_nxt;
    ho_r     <= ho_nxt;
    active_r <= (wo_nxt != '0) && (ho_nxt != '0);
  end

  always_comb begin
    cfg.w       = wc_r;
    cfg.h       = hc_r;
    cfg.wo      = wo_r;
    cfg.ho      = ho_r;
    cfg.active  = active_r;
    cfg.settled = (settle_r == 2'd0);
    cfg.restart = wr_valid;
  end

endmodule

FILE: rtl/nnd_core.sv
// Pixel pipeline of the downscaler: input register, position tracking and
// selection, result register. Depends on nnd_pkg and the stream interfaces.
module nnd_core import nnd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  nnd_pix_if.sink     in_pix,
  nnd_res_if.source   out_res
);

  logic             s1_valid_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [W_W-1:0]   ocol_r, ocol_nxt;
  logic [H_W-1:0]   orow_r, orow_nxt;
  acc_t             dcol_r, dcol_nxt;
  acc_t             drow_r, drow_nxt;

  logic             out_valid_r;
  pix_t             out_pix_r;
  logic             out_row_end_r, out_frame_end_r;

  logic out_free, advance, accept;
  logic col_match, row_match, row_open, emit;
  logic row_end_c, frame_end_c, last_col, last_row;
  acc_t w_acc, h_acc, wo_acc, ho_acc;

  assign w_acc  = acc_t'(cfg.w);
  assign h_acc  = acc_t'(cfg.h);
  assign wo_acc = acc_t'(cfg.wo);
  assign ho_acc = acc_t'(cfg.ho);

  assign out_free     = !out_valid_r || out_res.ready;
  assign advance      = s1_valid_r && out_free;
  assign in_pix.ready = cfg.settled && (!s1_valid_r || out_free);
  assign accept       = in_pix.valid && in_pix.ready;

  // dcol = j*W - c*Wo: column c is the source of output column j exactly
  // when 0 <= dcol < Wo. drow does the same for rows.
  assign col_match = !dcol_r[ACC_W-1] && (dcol_r < wo_acc);
  assign row_match = !drow_r[ACC_W-1] && (drow_r < ho_acc);
  assign row_open  = cfg.active && (orow_r < cfg.ho);
  assign emit      = row_open && (ocol_r < cfg.wo) && col_match && row_match;

  assign row_end_c   = (ocol_r == cfg.wo - W_W'(1));
  assign frame_end_c = row_end_c && (orow_r == cfg.ho - H_W'(1));
  assign last_col    = ((W_W'(col_r) + W_W'(1)) >= cfg.w);
  assign last_row    = ((H_W'(row_r) + H_W'(1)) >= cfg.h);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    dcol_nxt = dcol_r;
    drow_nxt = drow_r;
    if (advance) begin
      if (emit) begin
        ocol_nxt = ocol_r + W_W'(1);
        dcol_nxt = dcol_r + w_acc - wo_acc;
      end else begin
        dcol_nxt = dcol_r - wo_acc;
      end
      if (last_col) begin
        col_nxt  = '0;
        ocol_nxt = '0;
        dcol_nxt = '0;
        if (row_open && row_match) begin
          orow_nxt = orow_r + H_W'(1);
          drow_nxt = drow_r + h_acc - ho_acc;
        end else begin
          drow_nxt = drow_r - ho_acc;
        end
        if (last_row) begin
          row_nxt  = '0;
          orow_nxt = '0;
          drow_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    if (cfg.restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
      dcol_nxt = '0;
      drow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      dcol_r      <= '0;
      drow_r      <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      dcol_r <= dcol_nxt;
      drow_r <= drow_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= advance && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r.blue  <= in_pix.blue_in;
      s1_pix_r.green <= in_pix.green_in;
      s1_pix_r.red   <= in_pix.red_in;
    end
    if (advance && emit) begin
      out_pix_r       <= s1_pix_r;
      out_row_end_r   <= row_end_c;
      out_frame_end_r <= frame_end_c;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.blue_out  = out_pix_r.blue;
  assign out_res.green_out = out_pix_r.green;
  assign out_res.red_out   = out_pix_r.red;
  assign out_res.row_end   = out_row_end_r;
  assign out_res.frame_end = out_frame_end_r;

endmodule

FILE: rtl/nearest_neighbor_downscaler.sv
// Nearest-neighbor image downscaler, top level.
// Depends on nnd_pkg, nnd_stream_if, nnd_cfg, nnd_core and the defines header.
//
// Usage: BGR pixels of a frame arrive in raster order on in_pix, one
// transaction per pixel. Each pixel that is the nearest source of an output
// pixel leaves on out_res via the input and result registers, with row_end
// on the last pixel of an output row and frame_end on the last pixel of the
// frame; all other pixels are dropped. The output is floor(W*p/100) by
// floor(H*p/100); an empty output or a percent outside 1..100 drops all.
// Throughput is one pixel per clock: the input register and the result
// register are separate stages, so a new pixel is taken while a result waits.
// When out_res stalls, the waiting result holds and in_pix.ready falls once
// the input register is also full.
// The APB-style port holds width, height and percent at byte addresses
// 0, 4 and 8. A write to one of them restarts the frame; after reset or
// any write in_pix.ready stays low while the size multiply and the divide
// by 100 settle. Reset restores 640 by 480 at 100 percent.
`include "nearest_neighbor_downscaler_defines.svh"

module nearest_neighbor_downscaler import nnd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  nnd_pix_if.sink           in_pix,
  nnd_res_if.source         out_res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  nnd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nnd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_pix  (in_pix),
    .out_res (out_res)
  );

  `NND_ASSERT_NEXT(a_write_holds_input, psel && penable && pwrite, !in_pix.ready, "input taken while sizes settle")
  `NND_ASSERT_NOW(a_frame_end_on_row_end, out_res.valid && out_res.frame_end, out_res.row_end, "frame end without row end")
  `NND_ASSERT_RST(a_reset_clears, !rst_n, !out_res.valid && !in_pix.ready, "pipeline not empty after reset")

endmodule

FILE: sim/nearest_neighbor_downscaler_tb.sv
// Self-checking testbench of the nearest-neighbor downscaler: pixel frames in, kept pixels out.
// Depends on nnd_pkg, the stream interfaces in nnd_stream_if and the top level
// nearest_neighbor_downscaler.
module nearest_neighbor_downscaler_tb import nnd_pkg::*; ;

  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 80;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             row_end;
    logic             frame_end;
  } kept_pixel_t;

  // Tracks the frame position and the expected kept pixels.
  class kept_pixel_board;
    logic [CFG_DIM_W-1:0] width_reg, height_reg;
    logic [PCT_W-1:0]     percent_reg;
    logic [COL_W-1:0]     in_col;
    logic [ROW_W-1:0]     in_row;
    logic [W_W-1:0]       out_col, src_col;
    logic [H_W-1:0]       out_row, src_row;
    kept_pixel_t          expected_kept[$];
    int                   errors;

    function new();
      width_reg   = 640;
      height_reg  = 480;
      percent_reg = 100;
      errors      = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      in_col  = '0;
      in_row  = '0;
      out_col = '0;
      out_row = '0;
      src_col = '0;
      src_row = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_FRAME_WIDTH:   width_reg   = value[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:  height_reg  = value[CFG_DIM_W-1:0];
        REG_SCALE_PERCENT: percent_reg = value[PCT_W-1:0];
        default:           ;
      endcase
      restart_frame();
    endfunction

    function void note_pixel(pix_t px);
      int          w, h, wo, ho;
      bit          active;
      kept_pixel_t k;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
      h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
      if (percent_reg >= 1 && percent_reg <= PCT_FULL) begin
        wo = (w * int'(percent_reg)) / PCT_FULL;
        ho = (h * int'(percent_reg)) / PCT_FULL;
      end else begin
        wo = 0;
        ho = 0;
      end
      active = (wo > 0) && (ho > 0);

      if (active && int'(out_row) < ho && int'(out_col) < wo &&
          in_col == src_col && in_row == src_row) begin
        k.blue      = px.blue;
        k.green     = px.green;
        k.red       = px.red;
        k.row_end   = (int'(out_col) == wo - 1);
        k.frame_end = k.row_end && (int'(out_row) == ho - 1);
        expected_kept.push_back(k);
        out_col++;
        src_col = W_W'((int'(out_col) * w) / wo);
      end

      if (int'(in_col) + 1 >= w) begin
        in_col = '0;
        // The source row advances only once the current source row has passed.
        if (active && int'(out_row) < ho && in_row == src_row) begin
          out_row++;
          src_row = H_W'((int'(out_row) * h) / ho);
        end
        out_col = '0;
        src_col = '0;
        if (int'(in_row) + 1 >= h) begin
          restart_frame();
        end else begin
          in_row++;
        end
      end else begin
        in_col++;
      end
    endfunction

    function void field_check(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_kept(kept_pixel_t got);
      kept_pixel_t want;
      if (expected_kept.size() == 0) begin
        $display("%0t: unexpected kept pixel, expected none, got %p", $time, got);
        errors++;
        return;
      end
      want = expected_kept.pop_front();
      field_check("blue_out", want.blue, got.blue);
      field_check("green_out", want.green, got.green);
      field_check("red_out", want.red, got.red);
      field_check("row_end", want.row_end, got.row_end);
      field_check("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  nnd_pix_if in_pix();
  nnd_res_if out_res();

  nearest_neighbor_downscaler dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_res (out_res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kept_pixel_board board;
  bit              hold_request;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_pixel(input pix_t px, input bit gapless);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid    <= 1'b1;
    in_pix.blue_in  <= px.blue;
    in_pix.green_in <= px.green;
    in_pix.red_in   <= px.red;
    do @(posedge clk); while (!in_pix.ready);
    board.note_pixel(px);
  endtask

  // Stops offering pixels until every kept pixel has come out.
  task automatic drain(input int extra);
    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_kept.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // The input register may still hold a pixel that keeps nothing, so drain
  // also idles past the last result before touching the registers.
  task automatic configure(input int w, input int h, input int p);
    drain(6);
    write_reg(REG_FRAME_WIDTH, DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, DATA_W'(h));
    write_reg(REG_SCALE_PERCENT, DATA_W'(p));
  endtask

  task automatic send_random(input int count, input bit gapless);
    repeat (count) send_pixel(24'($urandom), gapless);
  endtask

  // Result side: ready is decided once per cycle, after the handshake is sampled.
  initial begin
    int          stall_left;
    bit          quiet;
    kept_pixel_t got;
    stall_left    = 0;
    quiet         = 1'b0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_res.valid && out_res.ready) begin
        got.blue      = out_res.blue_out;
        got.green     = out_res.green_out;
        got.red       = out_res.red_out;
        got.row_end   = out_res.row_end;
        got.frame_end = out_res.frame_end;
        board.check_kept(got);
        if ($urandom_range(0, 31) == 0) quiet = !quiet;
        stall_left = quiet ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_request) begin
        stall_left   = LONG_HOLD;
        hold_request = 1'b0;
      end
      out_res.ready <= (stall_left == 0);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_pix.valid && in_pix.ready) || (out_res.valid && out_res.ready) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("nearest_neighbor_downscaler_tb failed");
    $finish;
  end

  initial begin
    int w, h, p, n, r, k, pause_at, random_count;
    bit gapless;
    board           = new();
    hold_request    = 1'b0;
    random_count    = 0;
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_pix.valid    <= 1'b0;
    in_pix.blue_in  <= '0;
    in_pix.green_in <= '0;
    in_pix.red_in   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry, full scale: every pixel is kept.
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hffffff, 1'b0);
    send_pixel(24'haa55aa, 1'b0);
    send_pixel(24'h55aa55, 1'b0);

    // Tiny frame that wraps, with row and frame ends.
    configure(3, 2, 100);
    send_random(7, 1'b0);
    // Half scale skips columns and rows.
    configure(4, 3, 50);
    send_random(6, 1'b0);
    // Zero width counts as one column.
    configure(0, 2, 100);
    send_random(2, 1'b0);
    // Percent of zero and above one hundred keep nothing.
    configure(2, 2, 0);
    send_random(2, 1'b0);
    configure(2, 2, 127);
    send_random(2, 1'b0);
    // Output that rounds down to nothing.
    configure(1, 1, 50);
    send_random(1, 1'b0);
    // Oversized registers saturate to the largest frame.
    configure(8191, 8191, 100);
    send_random(2, 1'b0);

    // Largest frame at the smallest scale: a kept pixel every 102 or 103 columns.
    configure(4096, 4096, 1);
    send_random(210, 1'b1);

    // Hold the result side off so the block fills up and stalls its input.
    configure(5, 4, 100);
    hold_request = 1'b1;
    send_random(20, 1'b1);

    while (random_count < 150) begin
      r = $urandom_range(0, 15);
      w = (r == 0) ? $urandom_range(0, 8191) : (r == 1) ? 0 : $urandom_range(1, 12);
      r = $urandom_range(0, 15);
      h = (r == 0) ? $urandom_range(0, 8191) : (r == 1) ? 0 : $urandom_range(1, 8);
      r = $urandom_range(0, 9);
      case (r)
        0:       p = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(101, 127);
        1:       p = 100;
        2:       p = $urandom_range(1, 19);
        default: p = $urandom_range(20, 100);
      endcase
      if (w >= 1 && w <= 12 && h >= 1 && h <= 8) begin
        n = w * h + $urandom_range(0, w * h);
      end else begin
        n = $urandom_range(5, 40);
      end
      gapless  = ($urandom_range(0, 3) == 0);
      pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : -1;
      configure(w, h, p);
      for (k = 0; k < n; k++) begin
        if (k == pause_at) drain(0);
        send_pixel(24'($urandom), gapless);
        random_count++;
      end
    end

    drain(10);
    if (board.expected_kept.size() != 0) begin
      $display("%0t: %0d kept pixels never came out", $time, board.expected_kept.size());
    end
    if (board.errors == 0 && board.expected_kept.size() == 0) begin
      $display("nearest_neighbor_downscaler_tb passed");
    end else begin
      $display("nearest_neighbor_downscaler_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/nnd_pkg.sv
rtl/nnd_stream_if.sv
rtl/nnd_cfg.sv
rtl/nnd_core.sv
rtl/nearest_neighbor_downscaler.sv
sim/nearest_neighbor_downscaler_tb.sv
